>>> rtl/core/pfx_pkg.sv
// Package for the postfix expression evaluator: character codes, stack sizing,
// the command format between front and back, status codes and state types.
// No dependencies.
package pfx_pkg;

	localparam int STACK_DEPTH = 32;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_DIVZERO   = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// One command per character that is not a digit or that ends the
	// expression. The back end applies push, then op, then finish.
	typedef struct packed {
		logic        push;
		logic [31:0] num;
		op_t         op;
		logic        fin;
	} cmd_t;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
	} div_rsp_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PUSH,
		BK_OPRD,
		BK_OPEX,
		BK_DIV,
		BK_FIN
	} back_state_t;

endpackage

>>> rtl/core/pfx_in_if.sv
// Input channel of the evaluator: one character per transaction.
// No dependencies.
interface pfx_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink (input valid, input ch, input last, output ready);
endinterface

>>> rtl/core/pfx_out_if.sv
// Output channel of the evaluator: one result per expression.
// No dependencies.
interface pfx_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [1:0]         status;

	modport source (output valid, output value, output status, input ready);
	modport sink (input valid, input value, input status, output ready);
endinterface

>>> rtl/core/pfx_front.sv
// Front end: accepts characters, builds decimal numbers and turns each
// non-digit or last character into a stack command. Depends on pfx_pkg, pfx_in_if.
module pfx_front (
	input  logic           clk,
	input  logic           arst_n,
	pfx_in_if.sink         in_chan,
	input  logic           fifo_full,
	output logic           fifo_push,
	output pfx_pkg::cmd_t  fifo_cmd
);
	import pfx_pkg::*;

	logic [31:0] acc_q;
	logic        in_num_q;
	logic        is_digit;
	logic [3:0]  digit;
	logic [31:0] acc_next;
	logic        accept;
	op_t         op;

	assign in_chan.ready = !fifo_full;
	assign accept        = in_chan.valid && in_chan.ready;

	always_comb begin
		is_digit = (in_chan.ch >= CH_ZERO) && (in_chan.ch <= CH_NINE);
		digit    = 4'(in_chan.ch - CH_ZERO);
		acc_next = (acc_q << 3) + (acc_q << 1) + {28'd0, digit};
		case (in_chan.ch)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			CH_SLASH: op = OP_DIV;
			default:  op = OP_NONE;
		endcase
	end

	// A digit that is not last only feeds the accumulator; everything else
	// produces one command.
	always_comb begin
		fifo_push    = accept && (!is_digit || in_chan.last);
		fifo_cmd.fin = in_chan.last;
		if (is_digit) begin
			fifo_cmd.push = 1'b1;
			fifo_cmd.num  = acc_next;
			fifo_cmd.op   = OP_NONE;
		end else begin
			fifo_cmd.push = in_num_q;
			fifo_cmd.num  = acc_q;
			fifo_cmd.op   = op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			in_num_q <= 1'b0;
		end else if (accept) begin
			if (is_digit && !in_chan.last) begin
				acc_q    <= acc_next;
				in_num_q <= 1'b1;
			end else begin
				acc_q    <= '0;
				in_num_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/pfx_cmd_fifo.sv
// Short command queue between the front and back ends.
// Depends on pfx_pkg.
module pfx_cmd_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pfx_pkg::cmd_t  wdata,
	input  logic           pop,
	output pfx_pkg::cmd_t  rdata,
	output logic           full,
	output logic           empty
);
	import pfx_pkg::*;

	cmd_t                  entry_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_PTR_W:0]   fill_q;

	assign full  = (fill_q == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
	assign empty = (fill_q == '0);
	assign rdata = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			entry_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop && !empty) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			if ((push && !full) && !(pop && !empty)) begin
				fill_q <= fill_q + (FIFO_PTR_W + 1)'(1);
			end else if (!(push && !full) && (pop && !empty)) begin
				fill_q <= fill_q - (FIFO_PTR_W + 1)'(1);
			end
		end
	end

endmodule

>>> rtl/core/pfx_divider.sv
// Iterative signed 32-bit divider, truncating toward zero, one quotient bit
// per cycle. Depends on pfx_pkg.
module pfx_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  pfx_pkg::div_req_t  req,
	output pfx_pkg::div_rsp_t  rsp
);
	import pfx_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic        neg_q;
	logic [32:0] trial;

	assign trial        = {rem_q, quo_q[31]} - {1'b0, dvs_q};
	assign rsp.done     = done_q;
	assign rsp.quotient = neg_q ? (32'd0 - quo_q) : quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
			dvs_q <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
			neg_q <= req.dividend[31] ^ req.divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= {rem_q[30:0], quo_q[31]};
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0);
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 5'd1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

>>> rtl/core/pfx_back.sv
// Back end: executes stack commands against the value stack, runs the
// divider and holds the result register. Depends on pfx_pkg, pfx_out_if,
// pfx_divider.
module pfx_back (
	input  logic           clk,
	input  logic           arst_n,
	input  pfx_pkg::cmd_t  fifo_cmd,
	input  logic           fifo_empty,
	output logic           fifo_pop,
	pfx_out_if.source      out_chan
);
	import pfx_pkg::*;

	back_state_t        state_q;
	back_state_t        state_d;
	cmd_t               cmd_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_d;
	logic [31:0]        tos_q;
	logic [31:0]        tos_d;
	logic [31:0]        rd_q;
	status_t            err_q;
	status_t            err_d;
	logic [31:0]        mem [STACK_DEPTH];
	logic               mem_we;
	logic               rd_en;
	logic [CNT_W-1:0]   wr_idx;
	logic [CNT_W-1:0]   rd_idx;
	logic               out_load;
	logic               out_valid_q;
	logic [31:0]        out_value_q;
	status_t            out_status_q;
	back_state_t        after_push;
	back_state_t        after_op;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	pfx_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign wr_idx           = count_q - CNT_W'(1);
	assign rd_idx           = count_q - CNT_W'(2);

	assign out_chan.valid  = out_valid_q;
	assign out_chan.value  = out_value_q;
	assign out_chan.status = out_status_q;

	always_comb begin
		after_op   = cmd_q.fin ? BK_FIN : BK_IDLE;
		after_push = (cmd_q.op != OP_NONE) ? BK_OPRD : after_op;
	end

	always_comb begin
		state_d          = state_q;
		count_d          = count_q;
		tos_d            = tos_q;
		err_d            = err_q;
		fifo_pop         = 1'b0;
		mem_we           = 1'b0;
		rd_en            = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = rd_q;
		div_req.divisor  = tos_q;
		out_load         = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (!fifo_empty) begin
					fifo_pop = 1'b1;
					state_d  = BK_PUSH;
				end
			end
			BK_PUSH: begin
				if (cmd_q.push && (err_q == ST_OK)) begin
					if (count_q == CNT_W'(STACK_DEPTH)) begin
						err_d = ST_OVERFLOW;
					end else begin
						// The old top moves into the memory; the new value stays in tos_q.
						mem_we  = (count_q != '0);
						tos_d   = cmd_q.num;
						count_d = count_q + CNT_W'(1);
					end
				end
				state_d = after_push;
			end
			BK_OPRD: begin
				if (err_q != ST_OK) begin
					state_d = after_op;
				end else if (count_q < CNT_W'(2)) begin
					err_d   = ST_UNDERFLOW;
					state_d = after_op;
				end else begin
					rd_en   = 1'b1;
					state_d = BK_OPEX;
				end
			end
			BK_OPEX: begin
				state_d = after_op;
				case (cmd_q.op)
					OP_ADD: begin
						tos_d   = rd_q + tos_q;
						count_d = count_q - CNT_W'(1);
					end
					OP_SUB: begin
						tos_d   = rd_q - tos_q;
						count_d = count_q - CNT_W'(1);
					end
					OP_MUL: begin
						tos_d   = 32'(rd_q * tos_q);
						count_d = count_q - CNT_W'(1);
					end
					OP_DIV: begin
						if (tos_q == '0) begin
							err_d   = ST_DIVZERO;
							count_d = count_q - CNT_W'(2);
						end else begin
							div_req.start = 1'b1;
							state_d       = BK_DIV;
						end
					end
					default: begin
						state_d = after_op;
					end
				endcase
			end
			BK_DIV: begin
				if (div_rsp.done) begin
					tos_d   = div_rsp.quotient;
					count_d = count_q - CNT_W'(1);
					state_d = after_op;
				end
			end
			BK_FIN: begin
				if (!out_valid_q || out_chan.ready) begin
					out_load = 1'b1;
					count_d  = '0;
					err_d    = ST_OK;
					state_d  = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			err_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			err_q   <= err_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_chan.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		tos_q <= tos_d;
		if (fifo_pop) begin
			cmd_q <= fifo_cmd;
		end
		if (out_load) begin
			if (err_q != ST_OK) begin
				out_status_q <= err_q;
				out_value_q  <= '0;
			end else if (count_q == '0) begin
				out_status_q <= ST_UNDERFLOW;
				out_value_q  <= '0;
			end else begin
				out_status_q <= ST_OK;
				out_value_q  <= tos_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx[ADDR_W-1:0]] <= tos_q;
		end
		if (rd_en) begin
			rd_q <= mem[rd_idx[ADDR_W-1:0]];
		end
	end

endmodule

>>> rtl/core/postfix_expression_evaluator.sv
// Postfix expression evaluator, top level. A digit that is not last only feeds
// the number accumulator. Other characters pass a 4-entry command queue to the
// stack engine, which takes one command at a time and runs '/' through the
// one-bit-per-cycle divider. Characters are accepted while the queue is not full.
// Reset clears the stack count, number accumulator, error status, queue fill
// and result valid flag; stack contents and the result value are not cleared.
module postfix_expression_evaluator (
	input  logic       clk,
	input  logic       arst_n,
	pfx_in_if.sink     in_chan,
	pfx_out_if.source  out_chan
);
	import pfx_pkg::*;

	logic fifo_push;
	logic fifo_pop;
	logic fifo_full;
	logic fifo_empty;
	cmd_t front_cmd;
	cmd_t back_cmd;

	pfx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_chan   (in_chan),
		.fifo_full (fifo_full),
		.fifo_push (fifo_push),
		.fifo_cmd  (front_cmd)
	);

	pfx_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fifo_push),
		.wdata  (front_cmd),
		.pop    (fifo_pop),
		.rdata  (back_cmd),
		.full   (fifo_full),
		.empty  (fifo_empty)
	);

	pfx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_cmd   (back_cmd),
		.fifo_empty (fifo_empty),
		.fifo_pop   (fifo_pop),
		.out_chan   (out_chan)
	);

	// Any error result carries a zero value.
	a_err_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_chan.valid && (out_chan.status != ST_OK)) |-> (out_chan.value == 32'd0))
		else $error("error result with nonzero value");

	// The front end never writes a full queue.
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_push |-> !fifo_full)
		else $error("command pushed into full queue");

	// The back end never reads an empty queue.
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_pop |-> !fifo_empty)
		else $error("command popped from empty queue");

endmodule

>>> tb/sv/postfix_expression_evaluator_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for postfix_expression_evaluator: directed expressions from a table,
// then random expressions under three idling patterns, checked against typed-in results or a predictor.
// Depends on pfx_pkg, pfx_in_if, pfx_out_if and the postfix_expression_evaluator RTL.
module postfix_expression_evaluator_test;
	import pfx_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int STALL_LIMIT  = 2000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 60;
	localparam int PHASE_CHARS  = 520;
	localparam int MAX_REPORTS  = 10;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;

	typedef struct packed {
		logic [7:0]  ch;
		logic        last;
		logic        typed_in;
		logic [31:0] value;
		status_t     status;
	} char_item_t;

	typedef struct packed {
		logic [31:0] value;
		status_t     status;
	} eval_result_t;

	typedef struct {
		string       text;
		bit          typed_in;
		logic [31:0] value;
		status_t     status;
	} directed_row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	pfx_in_if  in_chan ();
	pfx_out_if out_chan ();

	postfix_expression_evaluator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_chan  (in_chan),
		.out_chan (out_chan)
	);

	always #HALF_PERIOD clk = ~clk;

	// A '#' in a row stands for the zero byte, which a string cannot hold.
	directed_row_t directed_rows [$] = '{
		'{"7", 1'b1, 32'd7, ST_OK},
		'{" ", 1'b1, 32'd0, ST_UNDERFLOW},
		'{"#", 1'b1, 32'd0, ST_UNDERFLOW},
		'{"0", 1'b1, 32'd0, ST_OK},
		'{"3 4+", 1'b0, 32'd0, ST_OK},
		'{"9 5-", 1'b0, 32'd0, ST_OK},
		'{"5 9-", 1'b0, 32'd0, ST_OK},
		'{"6 7*", 1'b0, 32'd0, ST_OK},
		'{"7 2/", 1'b0, 32'd0, ST_OK},
		'{"7 0 2-/", 1'b0, 32'd0, ST_OK},
		'{"1 0/", 1'b1, 32'd0, ST_DIVZERO},
		'{"+", 1'b1, 32'd0, ST_UNDERFLOW},
		'{"5+", 1'b1, 32'd0, ST_UNDERFLOW},
		'{"4294967297", 1'b1, 32'd1, ST_OK},
		'{"4294967295", 1'b1, 32'hFFFF_FFFF, ST_OK},
		'{"99999999999 3-", 1'b0, 32'd0, ST_OK},
		'{"2147483648 0 1-/", 1'b1, 32'h8000_0000, ST_OK},
		'{"2147483647 1+", 1'b1, 32'h8000_0000, ST_OK},
		'{"65536 65536*", 1'b1, 32'd0, ST_OK},
		'{"1 2 3", 1'b0, 32'd0, ST_OK},
		'{"12#34\377+", 1'b0, 32'd0, ST_OK},
		'{"1 0/ 5 5+", 1'b1, 32'd0, ST_DIVZERO},
		'{"+ 1 0/", 1'b1, 32'd0, ST_UNDERFLOW},
		'{{"1 1 1 1 1 1 1 1 1 1 ", "1 1 1 1 1 1 1 1 1 1 ", "1 1 1 1 1 1 1 1 1 1 ", "1 1 1"},
			1'b1, 32'd0, ST_OVERFLOW},
		'{"4 2", 1'b0, 32'd0, ST_OK},
		'{"9 8 7 6**-", 1'b0, 32'd0, ST_OK}
	};

	// Predictor state: operand stack, digit accumulator and first recorded error.
	logic [31:0] calc_stack [STACK_DEPTH];
	int          calc_count     = 0;
	logic [31:0] calc_acc       = '0;
	bit          calc_in_number = 1'b0;
	status_t     calc_error     = ST_OK;

	char_item_t   char_stream [$];
	logic [7:0]   expr_text [$];
	eval_result_t pending_results [$];
	char_item_t   offered_item;
	int           queued_chars    = 0;
	bit           prev_was_number = 1'b0;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_request  = 1'b0;
	int hold_left     = 0;

	bit in_took        = 1'b0;
	bit out_took       = 1'b0;
	int idle_cycles    = 0;
	int mismatch_count = 0;

	function void record_error(status_t code);
		if (calc_error == ST_OK) begin
			calc_error = code;
		end
	endfunction

	function void push_operand(logic [31:0] v);
		if (calc_error != ST_OK) begin
			return;
		end
		if (calc_count >= STACK_DEPTH) begin
			record_error(ST_OVERFLOW);
			return;
		end
		calc_stack[calc_count] = v;
		calc_count++;
	endfunction

	function void close_number();
		if (calc_in_number) begin
			push_operand(calc_acc);
		end
		calc_in_number = 1'b0;
		calc_acc = '0;
	endfunction

	function bit evaluate_char(logic [7:0] c, logic fin, output eval_result_t res);
		logic [31:0] a, b, r, ma, mb, q;
		bit          no_push;
		res = '{value: '0, status: ST_OK};
		if (c >= CH_ZERO && c <= CH_NINE) begin
			calc_acc = calc_acc * 32'd10 + 32'(c - CH_ZERO);
			calc_in_number = 1'b1;
		end else begin
			close_number();
			if ((c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH)
					&& calc_error == ST_OK) begin
				if (calc_count < 2) begin
					record_error(ST_UNDERFLOW);
				end else begin
					b = calc_stack[calc_count - 1];
					a = calc_stack[calc_count - 2];
					calc_count -= 2;
					no_push = 1'b0;
					r = '0;
					case (c)
						CH_PLUS:  r = a + b;
						CH_MINUS: r = a - b;
						CH_STAR:  r = a * b;
						default: begin
							// Divide magnitudes, then fix the sign, so the quotient
							// truncates toward zero and the most negative value wraps.
							if (b == '0) begin
								record_error(ST_DIVZERO);
								no_push = 1'b1;
							end else begin
								ma = a[31] ? -a : a;
								mb = b[31] ? -b : b;
								q  = ma / mb;
								r  = (a[31] != b[31]) ? -q : q;
							end
						end
					endcase
					if (!no_push) begin
						push_operand(r);
					end
				end
			end
		end
		if (!fin) begin
			return 1'b0;
		end
		close_number();
		if (calc_error != ST_OK) begin
			res.status = calc_error;
		end else if (calc_count == 0) begin
			res.status = ST_UNDERFLOW;
		end else begin
			res.value = calc_stack[calc_count - 1];
		end
		calc_count     = 0;
		calc_acc       = '0;
		calc_in_number = 1'b0;
		calc_error     = ST_OK;
		return 1'b1;
	endfunction

	// Moves the characters built up in expr_text into the stimulus stream,
	// marking the final one as the end of the expression.
	task automatic flush_expression(bit typed_in, logic [31:0] value, status_t status);
		char_item_t item;
		foreach (expr_text[i]) begin
			item.ch       = expr_text[i];
			item.last     = (i == expr_text.size() - 1);
			item.typed_in = typed_in;
			item.value    = value;
			item.status   = status;
			char_stream.push_back(item);
			queued_chars++;
		end
		expr_text.delete();
	endtask

	task automatic add_separator(bit required);
		int         pick;
		logic [7:0] c;
		pick = $urandom_range(99);
		if (!required && pick < 40) begin
			return;
		end
		if (pick < 75) begin
			expr_text.push_back(CH_SPACE);
		end else begin
			do begin
				c = 8'($urandom_range(255));
			end while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS
					|| c == CH_STAR || c == CH_SLASH);
			expr_text.push_back(c);
		end
	endtask

	task automatic emit_number();
		int pick, len;
		add_separator(prev_was_number);
		pick = $urandom_range(99);
		if (pick < 15) begin
			len = 0;
		end else if (pick < 75) begin
			len = $urandom_range(1, 3);
		end else if (pick < 92) begin
			len = $urandom_range(4, 9);
		end else begin
			len = $urandom_range(10, 12);
		end
		if (len == 0) begin
			expr_text.push_back(CH_ZERO);
		end else begin
			repeat (len) expr_text.push_back(CH_ZERO + 8'($urandom_range(9)));
		end
		prev_was_number = 1'b1;
	endtask

	task automatic emit_operator();
		int pick;
		add_separator(1'b0);
		pick = $urandom_range(99);
		if (pick < 25) begin
			expr_text.push_back(CH_PLUS);
		end else if (pick < 50) begin
			expr_text.push_back(CH_MINUS);
		end else if (pick < 72) begin
			expr_text.push_back(CH_STAR);
		end else begin
			expr_text.push_back(CH_SLASH);
		end
		prev_was_number = 1'b0;
	endtask

	task automatic build_random_expression();
		int kind, pushes, depth, keep;
		kind = $urandom_range(99);
		prev_was_number = 1'b0;
		if (kind < 72) begin
			// Well-formed expression; now and then a few entries are left over.
			pushes = ($urandom_range(9) == 0) ? $urandom_range(7, 14) : $urandom_range(1, 5);
			keep   = ($urandom_range(7) == 0) ? $urandom_range(2, 3) : 1;
			depth  = 0;
			while (pushes > 0 || depth > keep) begin
				if (pushes > 0 && (depth < 2 || $urandom_range(1) == 0)) begin
					emit_number();
					pushes--;
					depth++;
				end else begin
					emit_operator();
					depth--;
				end
			end
		end else if (kind < 76) begin
			// Deep stack around the full mark.
			repeat ($urandom_range(28, 35)) emit_number();
			repeat ($urandom_range(0, 4)) emit_operator();
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 8)) begin
				if ($urandom_range(1) == 0) begin
					emit_number();
				end else begin
					emit_operator();
				end
			end
		end else begin
			repeat ($urandom_range(1, 6)) expr_text.push_back(8'($urandom_range(255)));
		end
		if ($urandom_range(2) == 0) begin
			add_separator(1'b1);
		end
	endtask

	task automatic queue_random_phase();
		int start;
		start = queued_chars;
		while (queued_chars - start < PHASE_CHARS) begin
			build_random_expression();
			flush_expression(1'b0, '0, ST_OK);
		end
	endtask

	// Sender: a new character is offered only once the previous one has been taken.
	always @(negedge clk) begin
		if (!in_chan.valid || in_took) begin
			if (char_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				offered_item = char_stream.pop_front();
				in_chan.valid <= 1'b1;
				in_chan.ch    <= offered_item.ch;
				in_chan.last  <= offered_item.last;
			end else begin
				in_chan.valid <= 1'b0;
			end
		end
	end

	// Receiver, with a long hold-off on request.
	always @(negedge clk) begin
		if (hold_request) begin
			hold_left    = HOLD_CYCLES;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_chan.ready <= 1'b0;
		end else begin
			out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		eval_result_t predicted, expected;
		bit           produced;
		in_took  = arst_n && in_chan.valid && in_chan.ready;
		out_took = arst_n && out_chan.valid && out_chan.ready;
		if (in_took) begin
			produced = evaluate_char(offered_item.ch, offered_item.last, predicted);
			if (produced) begin
				if (offered_item.typed_in) begin
					pending_results.push_back('{offered_item.value, offered_item.status});
				end else begin
					pending_results.push_back(predicted);
				end
			end
		end
		if (out_took) begin
			if (pending_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%0t: result with none expected: value %0d status %0d",
						$realtime, $signed(out_chan.value), out_chan.status);
				end
			end else begin
				expected = pending_results.pop_front();
				if (out_chan.value !== expected.value || out_chan.status !== expected.status) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%0t: mismatch: value %0d status %0d, expected value %0d status %0d",
							$realtime, $signed(out_chan.value), out_chan.status,
							$signed(expected.value), expected.status);
					end
				end
			end
		end
		if (in_took || out_took) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
		end
	end

	initial begin
		while (idle_cycles < STALL_LIMIT) @(posedge clk);
		$display("postfix_expression_evaluator test failed");
		$finish;
	end

	initial begin
		in_chan.valid  = 1'b0;
		in_chan.ch     = '0;
		in_chan.last   = 1'b0;
		out_chan.ready = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 18;
		recv_idle_pct = 59;
		foreach (directed_rows[i]) begin
			for (int j = 0; j < directed_rows[i].text.len(); j++) begin
				expr_text.push_back((directed_rows[i].text[j] == CH_HASH) ?
					8'h00 : directed_rows[i].text[j]);
			end
			flush_expression(directed_rows[i].typed_in, directed_rows[i].value,
				directed_rows[i].status);
		end
		queue_random_phase();
		while (char_stream.size() != 0) @(posedge clk);

		send_idle_pct = 59;
		recv_idle_pct = 18;
		queue_random_phase();
		while (char_stream.size() != 0) @(posedge clk);

		// No idling; the receiver first holds off so the block backs up.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_request  = 1'b1;
		queue_random_phase();
		while (char_stream.size() != 0 || in_chan.valid) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("postfix_expression_evaluator test passed");
		end else begin
			$display("postfix_expression_evaluator test failed");
		end
		$finish;
	end

endmodule
